// File: hdl/mrd_pkg.sv
// shared types and constants for the mqtt receive deframer
package mrd_pkg;

  localparam int MRD_MAX_LENGTH_BYTES = 4;
  localparam int MRD_QUEUE_DEPTH      = 2;
  localparam logic [15:0] MRD_MAX_PACKET_RESET = 16'd255;
  localparam logic [3:0]  MRD_TYPE_PUBLISH     = 4'd3;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_LENGTH  = 8'b0000_0010,
    PH_TLEN_HI = 8'b0000_0100,
    PH_TLEN_LO = 8'b0000_1000,
    PH_TOPIC   = 8'b0001_0000,
    PH_MID_HI  = 8'b0010_0000,
    PH_MID_LO  = 8'b0100_0000,
    PH_BODY    = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER = 3'd0,
    ROLE_LENGTH = 3'd1,
    ROLE_TLEN   = 3'd2,
    ROLE_TOPIC  = 3'd3,
    ROLE_MID    = 3'd4,
    ROLE_BODY   = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    QOS_0 = 2'd0,
    QOS_1 = 2'd1,
    QOS_2 = 2'd2,
    QOS_3 = 2'd3
  } qos_t;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       cont;
    logic       type_publish;
  } byte_item_t;

  // one result
  typedef struct packed {
    logic [7:0]  byte_value;
    role_t       byte_role;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] remaining_length;
    logic [2:0]  length_bytes;
    logic [15:0] topic_length;
    logic [15:0] message_id;
    logic        last_of_packet;
    status_t     status;
    logic        ack_needed;
  } result_t;

endpackage

// File: hdl/mrd_front.sv
// input stage: takes byte transfers and tags continuation and publish type
module mrd_front
  import mrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output byte_item_t out_item
);

  logic       fv;
  byte_item_t item;

  assign in_ready  = !fv || out_ready;
  assign out_valid = fv;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data         <= in_data;
      item.cont         <= in_data[7];
      item.type_publish <= (in_data[7:4] == MRD_TYPE_PUBLISH);
    end
  end

endmodule

// File: hdl/mrd_queue.sv
// short fifo between the front stage and the parser
module mrd_queue
  import mrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output byte_item_t out_item
);

  localparam int DEPTH = MRD_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  byte_item_t          mem [DEPTH];
  logic [PW-1:0]       wptr;
  logic [PW-1:0]       rptr;
  logic [CW-1:0]       count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

endmodule

// File: hdl/mrd_back.sv
// packet parser with output register
module mrd_back
  import mrd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MRD_MAX_LENGTH_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] max_packet_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  byte_item_t  in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  phase_t      phase, phase_next;
  logic [7:0]  hdr, hdr_next;
  logic [27:0] acc, acc_next;
  logic [2:0]  cnt, cnt_next;
  logic [27:0] left, left_next;
  logic [15:0] tlen, tlen_next;
  logic [15:0] tleft, tleft_next;
  logic [15:0] mid, mid_next;
  status_t     err, err_next;

  logic        mv;
  result_t     res;
  logic        advance;

  logic [7:0]  b;
  logic [27:0] acc_ins;
  logic [27:0] low7;
  logic [2:0]  cnt_inc;
  logic [28:0] size;
  logic [27:0] left_dec;
  logic [16:0] need;
  logic        has_mid;
  logic        is_pub;
  role_t       role;
  logic        last;
  logic        ack;

  assign in_ready   = !mv || out_ready;
  assign advance    = in_valid && in_ready;
  assign out_valid  = mv;
  assign out_result = res;

  assign b       = in_item.data;
  assign is_pub  = (hdr[7:4] == MRD_TYPE_PUBLISH);
  assign has_mid = (qos_t'(hdr[2:1]) == QOS_1) || (qos_t'(hdr[2:1]) == QOS_2);
  assign low7    = {21'd0, b[6:0]};
  assign left_dec = (left != '0) ? left - 28'd1 : left;
  assign cnt_inc = (cnt < 3'd7) ? cnt + 3'd1 : cnt;
  assign size    = {1'b0, acc_ins} + {26'd0, cnt_inc} + 29'd1;

  // base-128 digit placement
  always_comb begin
    case (cnt[1:0])
      2'd0:    acc_ins = acc | low7;
      2'd1:    acc_ins = acc | (low7 << 7);
      2'd2:    acc_ins = acc | (low7 << 14);
      default: acc_ins = acc | (low7 << 21);
    endcase
  end

  always_comb begin
    phase_next = phase;
    hdr_next   = hdr;
    acc_next   = acc;
    cnt_next   = cnt;
    left_next  = left;
    tlen_next  = tlen;
    tleft_next = tleft;
    mid_next   = mid;
    err_next   = err;
    role       = ROLE_BODY;
    last       = 1'b0;
    ack        = 1'b0;
    need       = {1'b0, tlen} + (has_mid ? 17'd2 : 17'd0);
    case (phase)
      PH_HEADER: begin
        hdr_next   = b;
        acc_next   = '0;
        cnt_next   = '0;
        left_next  = '0;
        tlen_next  = '0;
        tleft_next = '0;
        mid_next   = '0;
        err_next   = ST_OK;
        role       = ROLE_HEADER;
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        role     = ROLE_LENGTH;
        acc_next = acc_ins;
        cnt_next = cnt_inc;
        if (in_item.cont) begin
          if (cnt_inc >= 3'(MAX_LENGTH_BYTES)) begin
            err_next   = ST_MALFORMED;
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end else begin
          left_next = acc_ins;
          if (size > {13'd0, max_packet_size}) begin
            err_next = ST_TOO_LONG;
          end
          if (in_item.type_publish || is_pub) begin
            phase_next = PH_TLEN_HI;
          end else begin
            phase_next = PH_BODY;
          end
          if (!is_pub) begin
            phase_next = PH_BODY;
          end else if (acc_ins == '0) begin
            err_next = ST_MALFORMED;
          end
          if (acc_ins == '0) begin
            last       = 1'b1;
            phase_next = PH_HEADER;
          end
        end
      end
      default: begin
        left_next = left_dec;
        case (phase)
          PH_TLEN_HI: begin
            role      = ROLE_TLEN;
            tlen_next = {b, 8'd0};
            if (left_dec == '0) begin
              err_next = ST_MALFORMED;
            end
            phase_next = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            role      = ROLE_TLEN;
            tlen_next = {tlen[15:8], b};
            need      = {1'b0, tlen[15:8], b} + (has_mid ? 17'd2 : 17'd0);
            if ({11'd0, need} > left_dec) begin
              err_next   = ST_MALFORMED;
              phase_next = PH_BODY;
            end else if ({tlen[15:8], b} != '0) begin
              tleft_next = {tlen[15:8], b};
              phase_next = PH_TOPIC;
            end else begin
              phase_next = has_mid ? PH_MID_HI : PH_BODY;
            end
          end
          PH_TOPIC: begin
            role       = ROLE_TOPIC;
            tleft_next = (tleft != '0) ? tleft - 16'd1 : tleft;
            if (tleft <= 16'd1) begin
              phase_next = has_mid ? PH_MID_HI : PH_BODY;
            end
          end
          PH_MID_HI: begin
            role       = ROLE_MID;
            mid_next   = {b, 8'd0};
            phase_next = PH_MID_LO;
          end
          PH_MID_LO: begin
            role       = ROLE_MID;
            mid_next   = {mid[15:8], b};
            phase_next = PH_BODY;
          end
          default: begin
            role = ROLE_BODY;
          end
        endcase
        if (left_dec == '0) begin
          last       = 1'b1;
          phase_next = PH_HEADER;
          ack        = is_pub && (qos_t'(hdr[2:1]) == QOS_1) && (err_next == ST_OK);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hdr   <= '0;
      acc   <= '0;
      cnt   <= '0;
      left  <= '0;
      tlen  <= '0;
      tleft <= '0;
      mid   <= '0;
      err   <= ST_OK;
      mv    <= 1'b0;
    end else begin
      if (advance) begin
        phase <= phase_next;
        hdr   <= hdr_next;
        acc   <= acc_next;
        cnt   <= cnt_next;
        left  <= left_next;
        tlen  <= tlen_next;
        tleft <= tleft_next;
        mid   <= mid_next;
        err   <= err_next;
        mv    <= 1'b1;
      end else if (out_ready) begin
        mv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.byte_value       <= b;
      res.byte_role        <= role;
      res.packet_type      <= hdr_next[7:4];
      res.header_flags     <= hdr_next[3:0];
      res.remaining_length <= acc_next;
      res.length_bytes     <= cnt_next;
      res.topic_length     <= tlen_next;
      res.message_id       <= mid_next;
      res.last_of_packet   <= last;
      res.status           <= err_next;
      res.ack_needed       <= ack;
    end
  end

`ifndef SYNTHESIS
  a_ack_on_ok_last: assert property (@(posedge clk) disable iff (rst)
    mv && res.ack_needed |-> res.last_of_packet && res.status == ST_OK)
    else $error("ack without ok last byte");

  a_len_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(MAX_LENGTH_BYTES))
    else $error("length byte count past limit");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEADER && phase != PH_LENGTH) |-> left != '0)
    else $error("packet body phase with no bytes left");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    mv && res.byte_role == ROLE_HEADER |->
      res.remaining_length == '0 && res.length_bytes == '0 && !res.last_of_packet)
    else $error("header byte carries stale fields");
`endif

endmodule

// File: hdl/mqtt_receive_deframer_core.sv
// mqtt receive deframer top level: byte stream in, tagged bytes out
// path: each byte is registered in the front stage, passes the queue, then is held in the output register
// throughput: one byte per cycle sustained while m_tready stays high; the parser updates its state once per byte
// the front register, a two-entry queue and the output register let either side stall alone
// reset (rst, synchronous): parser expects a header byte, queue and outputs empty
// reset also sets max_packet_size to 255
module mqtt_receive_deframer_core
  import mrd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MRD_MAX_LENGTH_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // max_packet_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // byte_value, packet_type, header_flags, remaining_length, length_bytes,
  // topic_length, message_id, status, ack_needed, zero fill
  output logic [87:0] m_tdata,
  output logic        m_tlast,    // last_of_packet
  output logic [2:0]  m_tuser     // byte_role
);

  logic [15:0] max_packet_size;
  logic        f_valid;
  logic        f_ready;
  byte_item_t  f_item;
  logic        q_valid;
  logic        q_ready;
  byte_item_t  q_item;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_size <= MRD_MAX_PACKET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_packet_size <= cfg_data;
    end
  end

  mrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  mrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  mrd_back #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .max_packet_size (max_packet_size),
    .in_valid        (q_valid),
    .in_ready        (q_ready),
    .in_item         (q_item),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_result      (res)
  );

  assign m_tdata = {6'd0,
                    res.ack_needed,
                    res.status,
                    res.message_id,
                    res.topic_length,
                    res.length_bytes,
                    res.remaining_length,
                    res.header_flags,
                    res.packet_type,
                    res.byte_value};
  assign m_tlast = res.last_of_packet;
  assign m_tuser = res.byte_role;

endmodule

// File: tb/tb_mqtt_receive_deframer_core.sv
// self-checking testbench for the mqtt receive deframer core
module tb_mqtt_receive_deframer_core;
  import mrd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  mqtt_receive_deframer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0] rx_pending[$];
  result_t    expected_tags[$];
  int         queued_bytes = 0;
  int         errors = 0;

  // parser copy
  phase_t      ph = PH_HEADER;
  logic [7:0]  hdr = '0;
  logic [27:0] len_acc = '0;
  logic [2:0]  len_cnt = '0;
  logic [27:0] bytes_left = '0;
  logic [15:0] tlen = '0;
  logic [15:0] topic_left = '0;
  logic [15:0] msg_id = '0;
  status_t     pkt_status = ST_OK;
  logic [15:0] max_size = MRD_MAX_PACKET_RESET;

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    role_t       role;
    logic        last;
    logic        ack;
    logic        pub;
    logic        has_mid;
    qos_t        qos;
    int unsigned total;
    int unsigned need;
    role = ROLE_BODY;
    last = 1'b0;
    ack  = 1'b0;
    if (ph == PH_HEADER) begin
      hdr        = b;
      len_acc    = '0;
      len_cnt    = '0;
      bytes_left = '0;
      tlen       = '0;
      topic_left = '0;
      msg_id     = '0;
      pkt_status = ST_OK;
      role       = ROLE_HEADER;
      ph         = PH_LENGTH;
    end else begin
      pub     = (hdr[7:4] == MRD_TYPE_PUBLISH);
      qos     = qos_t'(hdr[2:1]);
      has_mid = (qos == QOS_1) || (qos == QOS_2);
      if (ph == PH_LENGTH) begin
        role = ROLE_LENGTH;
        if (len_cnt < 4) len_acc = len_acc | (28'(b[6:0]) << (7 * len_cnt));
        if (len_cnt < 7) len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          if (len_cnt >= MRD_MAX_LENGTH_BYTES) begin
            pkt_status = ST_MALFORMED;
            last = 1'b1;
            ph = PH_HEADER;
          end
        end else begin
          total = 1 + len_cnt + len_acc;
          bytes_left = len_acc;
          if (total > max_size) pkt_status = ST_TOO_LONG;
          if (pub) begin
            if (len_acc == 0) pkt_status = ST_MALFORMED;
            ph = PH_TLEN_HI;
          end else begin
            ph = PH_BODY;
          end
          if (bytes_left == 0) begin
            last = 1'b1;
            ph = PH_HEADER;
          end
        end
      end else begin
        if (bytes_left > 0) bytes_left = bytes_left - 28'd1;
        case (ph)
          PH_TLEN_HI: begin
            role = ROLE_TLEN;
            tlen = {b, 8'h00};
            if (bytes_left == 0) pkt_status = ST_MALFORMED;
            ph = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            role = ROLE_TLEN;
            tlen = tlen | 16'(b);
            need = tlen + (has_mid ? 2 : 0);
            if (need > bytes_left) begin
              pkt_status = ST_MALFORMED;
              ph = PH_BODY;
            end else if (tlen > 0) begin
              topic_left = tlen;
              ph = PH_TOPIC;
            end else begin
              ph = has_mid ? PH_MID_HI : PH_BODY;
            end
          end
          PH_TOPIC: begin
            role = ROLE_TOPIC;
            if (topic_left > 0) topic_left = topic_left - 16'd1;
            if (topic_left == 0) ph = has_mid ? PH_MID_HI : PH_BODY;
          end
          PH_MID_HI: begin
            role = ROLE_MID;
            msg_id = {b, 8'h00};
            ph = PH_MID_LO;
          end
          PH_MID_LO: begin
            role = ROLE_MID;
            msg_id = msg_id | 16'(b);
            ph = PH_BODY;
          end
          default: role = ROLE_BODY;
        endcase
        if (bytes_left == 0) begin
          last = 1'b1;
          ph = PH_HEADER;
          if (pub && qos == QOS_1 && pkt_status == ST_OK) ack = 1'b1;
        end
      end
    end
    r.byte_value       = b;
    r.byte_role        = role;
    r.packet_type      = hdr[7:4];
    r.header_flags     = hdr[3:0];
    r.remaining_length = len_acc;
    r.length_bytes     = len_cnt;
    r.topic_length     = tlen;
    r.message_id       = msg_id;
    r.last_of_packet   = last;
    r.status           = pkt_status;
    r.ack_needed       = ack;
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : rx_driver
    logic       fire;
    logic       nv;
    logic [7:0] nd;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) expected_tags.push_back(deframe_byte(s_tdata));
      nv = s_tvalid && !fire;
      nd = s_tdata;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_pending.size() > 0) begin
          nv = 1'b1;
          nd = rx_pending.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_tvalid <= nv;
      s_tdata  <= nd;
    end
  end

  task automatic check_field(input string name, input logic [27:0] want,
                             input logic [27:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: stall pattern is one of four modes, re-picked at random whenever mon_cycle[5:0] wraps to zero
  int          ready_mode = 0;
  logic [15:0] mon_cycle = '0;

  always @(posedge clk) begin : tx_monitor
    result_t want;
    logic    nr;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tags.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual %0h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_value", want.byte_value, m_tdata[7:0]);
          check_field("byte_role", want.byte_role, m_tuser);
          check_field("packet_type", want.packet_type, m_tdata[11:8]);
          check_field("header_flags", want.header_flags, m_tdata[15:12]);
          check_field("remaining_length", want.remaining_length, m_tdata[43:16]);
          check_field("length_bytes", want.length_bytes, m_tdata[46:44]);
          check_field("topic_length", want.topic_length, m_tdata[62:47]);
          check_field("message_id", want.message_id, m_tdata[78:63]);
          check_field("last_of_packet", want.last_of_packet, m_tlast);
          check_field("status", want.status, m_tdata[80:79]);
          check_field("ack_needed", want.ack_needed, m_tdata[81]);
        end
      end
      mon_cycle = mon_cycle + 16'd1;
      if (mon_cycle[5:0] == 0) ready_mode = $urandom_range(3);
      case (ready_mode)
        0:       nr = 1'b1;
        1:       nr = 1'($urandom_range(1));
        2:       nr = (mon_cycle[2:0] == 0);
        default: nr = !mon_cycle[3];
      endcase
      m_tready <= nr;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    queued_bytes++;
  endtask

  // base-128 length, padded with continuation bytes up to nlen
  task automatic push_length(input int unsigned rem, input int nlen);
    logic [6:0] digits[$];
    do begin
      digits.push_back(7'(rem % 128));
      rem = rem / 128;
    end while (rem > 0);
    while (digits.size() < nlen) digits.push_back(7'd0);
    foreach (digits[i]) push_byte({(i < digits.size() - 1), digits[i]});
  endtask

  function automatic int pick_nlen();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 1;
  endfunction

  function automatic int pick_body_len();
    return ($urandom_range(9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
  endfunction

  task automatic push_publish();
    logic [1:0] qos;
    int         tl;
    int         pl;
    int         rem;
    qos = 2'($urandom_range(3));
    tl  = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 8);
    pl  = pick_body_len();
    rem = 2 + tl + ((qos == QOS_1 || qos == QOS_2) ? 2 : 0) + pl;
    push_byte({MRD_TYPE_PUBLISH, 1'($urandom), qos, 1'($urandom)});
    push_length(rem, pick_nlen());
    push_byte(8'(tl >> 8));
    push_byte(8'(tl));
    repeat (rem - 2) push_byte(8'($urandom));
  endtask

  task automatic push_other();
    logic [3:0] ptype;
    int         rem;
    do ptype = 4'($urandom); while (ptype == MRD_TYPE_PUBLISH);
    rem = pick_body_len();
    push_byte({ptype, 4'($urandom)});
    push_length(rem, pick_nlen());
    repeat (rem) push_byte(8'($urandom));
  endtask

  task automatic push_broken();
    int rem;
    case ($urandom_range(2))
      0: begin
        push_byte(8'($urandom));
        repeat (4) push_byte({1'b1, 7'($urandom)});
      end
      1: begin
        rem = $urandom_range(1, 6);
        push_byte({MRD_TYPE_PUBLISH, 4'($urandom)});
        push_length(rem, 1);
        push_byte(8'($urandom_range(1, 255)));
        repeat (rem - 1) push_byte(8'($urandom));
      end
      default: begin
        rem = $urandom_range(0, 12);
        push_byte(8'($urandom));
        push_length(rem, pick_nlen());
        repeat (rem) push_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic run_random(input int n);
    int start;
    int pick;
    start = queued_bytes;
    while (queued_bytes - start < n) begin
      pick = $urandom_range(9);
      if (pick < 5) push_publish();
      else if (pick < 8) push_other();
      else push_broken();
    end
  endtask

  task automatic drain();
    while (rx_pending.size() > 0 || s_tvalid || expected_tags.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    max_size = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed[];
    directed = '{
      8'hC0, 8'h00,
      8'h30, 8'h00,
      8'h20, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h32, 8'h07, 8'h00, 8'h02, 8'h61, 8'h62, 8'h12, 8'h34, 8'hFF,
      8'h34, 8'h03, 8'h00, 8'h05, 8'hAA,
      8'h30, 8'h01, 8'hFF
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) push_byte(directed[i]);
    drain();
    write_max_size(16'd2);
    run_random(150);
    drain();
    write_max_size(16'd65535);
    run_random(300);
    drain();
    write_max_size(16'($urandom_range(20, 400)));
    run_random(250);
    drain();
    write_max_size(16'd30);
    run_random(200);
    drain();
    if (errors == 0) begin
      $display("mqtt_receive_deframer_core test passed");
    end else begin
      $display("mqtt_receive_deframer_core test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("mqtt_receive_deframer_core test failed");
    $finish;
  end

endmodule

// File: mqtt_receive_deframer_core.f
hdl/mrd_pkg.sv
hdl/mrd_front.sv
hdl/mrd_queue.sv
hdl/mrd_back.sv
hdl/mqtt_receive_deframer_core.sv
tb/tb_mqtt_receive_deframer_core.sv
